@@ rtl/rad_pkg.sv @@
package rad_pkg;

  localparam int SUM_W   = 14;
  localparam int DIST_W  = 15;
  localparam int ANGLE_W = 3;
  localparam int SQ_W    = 4;

  // (pi/3)^2 in unsigned Q24, rounded to nearest.
  localparam int KQ_W = 25;
  localparam logic [KQ_W-1:0] KQ24 = 25'd18398276;

  localparam int PROD_W     = SUM_W + KQ_W;
  localparam int RAD_W      = 32;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 4;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_a;
    logic [ANGLE_W-1:0] angle_b;
    logic               last;
  } rad_in_t;

  typedef struct packed {
    logic [SUM_W-1:0]  square_sum;
    logic [DIST_W-1:0] distance_q8;
    logic              overflow;
  } rad_out_t;

  typedef struct packed {
    logic accumulate;
    logic launch;
    logic mul_en;
    logic root_step;
    logic out_load;
  } rad_cmd_t;

  // Squared step distance on the six-step ring; codes 6 and 7 wrap to 0 and 1.
  function automatic logic [SQ_W-1:0] ring_square(input logic [ANGLE_W-1:0] a,
                                                    input logic [ANGLE_W-1:0] b);
    logic [ANGLE_W-1:0] ra;
    logic [ANGLE_W-1:0] rb;
    logic [ANGLE_W-1:0] d;
    ra = (a >= 3'd6) ? a - 3'd6 : a;
    rb = (b >= 3'd6) ? b - 3'd6 : b;
    d  = (ra >= rb) ? ra - rb : rb - ra;
    if (d > 3'd3) begin
      d = 3'd6 - d;
    end
    case (d)
      3'd0:    ring_square = 4'd0;
      3'd1:    ring_square = 4'd1;
      3'd2:    ring_square = 4'd4;
      3'd3:    ring_square = 4'd9;
      default: ring_square = 4'd0;
    endcase
  endfunction

endpackage

@@ rtl/rad_ctrl.sv @@
module rad_ctrl
  import rad_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output rad_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_ACC,
    S_MUL,
    S_ROOT,
    S_FIN
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              accept;

  // A closing item waits until the previous result has been taken.
  assign in_stall = (state != S_ACC) || (in_last && out_valid);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.accumulate = accept;
    cmd.launch     = accept && in_last;
    cmd.mul_en     = (state == S_MUL);
    cmd.root_step  = (state == S_ROOT);
    cmd.out_load   = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACC;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_ACC: begin
          if (accept && in_last) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ROOT;
          step  <= '0;
        end
        S_ROOT: begin
          step <= step + 1'b1;
          if (step == STEP_W'(ROOT_STEPS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_ACC;
        end
        default: begin
          state <= S_ACC;
        end
      endcase

      if (state == S_FIN) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/rad_datapath.sv @@
module rad_datapath
  import rad_pkg::*;
#(
  parameter int MAX_SITES = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  rad_in_t  in_data,
  input  rad_cmd_t cmd,
  output rad_out_t out_data
);

  localparam int CNT_W = $clog2(MAX_SITES + 1);

  logic [SUM_W-1:0]  running_sum;
  logic [CNT_W-1:0]  pair_count;
  logic              saturated_flag;

  logic [SQ_W-1:0]   sq;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  count_next;
  logic              sat_next;

  logic [SUM_W-1:0]  snap_sum;
  logic              snap_sat;
  logic [PROD_W-1:0] product;

  logic [RAD_W-1:0]  radicand;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [REM_W-1:0]  rem_shift;
  logic [REM_W-1:0]  trial;

  assign sq = ring_square(in_data.angle_a, in_data.angle_b);

  always_comb begin
    if (pair_count >= CNT_W'(MAX_SITES)) begin
      sum_next   = running_sum;
      count_next = pair_count;
      sat_next   = 1'b1;
    end else begin
      sum_next   = running_sum + SUM_W'(sq);
      count_next = pair_count + 1'b1;
      sat_next   = saturated_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      pair_count     <= '0;
      saturated_flag <= 1'b0;
    end else if (cmd.launch) begin
      running_sum    <= '0;
      pair_count     <= '0;
      saturated_flag <= 1'b0;
    end else if (cmd.accumulate) begin
      running_sum    <= sum_next;
      pair_count     <= count_next;
      saturated_flag <= sat_next;
    end
  end

  assign product = PROD_W'(snap_sum) * PROD_W'(KQ24);

  // One result bit per step: bring down two radicand bits, try (root << 2) | 1.
  assign rem_shift = {rem[REM_W-3:0], radicand[RAD_W-1 -: 2]};
  assign trial     = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.launch) begin
      snap_sum <= sum_next;
      snap_sat <= sat_next;
    end
    if (cmd.mul_en) begin
      radicand <= RAD_W'(product >> 8);
      rem      <= '0;
      root     <= '0;
    end else if (cmd.root_step) begin
      radicand <= radicand << 2;
      if (rem_shift >= trial) begin
        rem  <= rem_shift - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_data.square_sum  <= snap_sum;
      out_data.distance_q8 <= root[DIST_W-1:0];
      out_data.overflow    <= snap_sat;
    end
  end

endmodule

@@ rtl/ring_angle_distance_core.sv @@
// Channel | Signals                      | Payload
// input   | in_valid, in_stall, in_data  | rad_in_t  (angle_a, angle_b, last)
// output  | out_valid, out_stall, out_data | rad_out_t (square_sum, distance_q8, overflow)
//
// An item without last is accepted every cycle while the core is idle and only updates the running sum.
// An item with last holds off the next item until its result is done: it is
// accumulated, then goes through the 14 x 25 bit scaling multiply and 16 steps of
// the one-bit-per-cycle square root unit, and then the output register is loaded.
// Reset is synchronous and clears the sum, the pair count and the result valid.
// A waiting result blocks only the next item with last; other items keep flowing.
module ring_angle_distance_core
  import rad_pkg::*;
#(
  parameter int MAX_SITES = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  rad_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rad_out_t out_data
);

  rad_cmd_t cmd;

  rad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rad_datapath #(
    .MAX_SITES (MAX_SITES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule

@@ rtl/rad_checker.sv @@
module rad_checker
  import rad_pkg::*;
#(
  parameter int MAX_SITES = 1024
) (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input rad_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input rad_out_t out_data
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // After a closing item the block is busy with the scaling multiply and the root.
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("item accepted right after a closing item");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_data.square_sum) <= 32'(9 * MAX_SITES))
    else $error("sum beyond its bound");

  a_zero_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.square_sum == '0) == (out_data.distance_q8 == '0)))
    else $error("distance and sum disagree on zero");

  a_new_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while input was open");

endmodule

bind ring_angle_distance_core rad_checker #(
  .MAX_SITES (MAX_SITES)
) u_rad_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
